// ===== src/csb_pkg.sv =====
// types, codes and constants shared by the clock set button controller
`default_nettype none

package csb_pkg;

  typedef enum logic [1:0] {
    KEY_PLUS   = 2'd0,
    KEY_SELECT = 2'd1,
    KEY_BACK   = 2'd2,
    KEY_MINUS  = 2'd3
  } key_t;

  localparam logic [1:0] VIEW_TIME = 2'd0;
  localparam logic [1:0] VIEW_DATE = 2'd1;
  localparam logic [1:0] VIEW_YEAR = 2'd2;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_TIME = 2'd1;
  localparam logic [1:0] WR_DATE = 2'd2;

  localparam logic [3:0] SHADE_HIGH = 4'h3;
  localparam logic [3:0] SHADE_LOW  = 4'hC;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [4:0] DAYS_28    = 5'd28;
  localparam logic [4:0] DAYS_29    = 5'd29;
  localparam logic [4:0] DAYS_30    = 5'd30;
  localparam logic [4:0] DAYS_31    = 5'd31;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] cur_hours;
    logic [5:0] cur_minutes;
    logic [3:0] cur_month;
    logic [4:0] cur_day;
    logic [6:0] cur_year;
  } req_t;

  typedef struct packed {
    logic [4:0] new_hours;
    logic [5:0] new_minutes;
    logic [3:0] new_month;
    logic [4:0] new_day;
    logic [6:0] new_year;
    logic [1:0] write_kind;
    logic [1:0] view_mode;
    logic       editing;
    logic       field_select;
    logic [3:0] shade_pattern;
    logic       shade_on;
    logic       leave_to_menu;
  } rsp_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [3:0] month;
    logic [4:0] day;
    logic [6:0] year;
  } date_time_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       edit;
    logic       sel;
    logic [3:0] shade;
    logic       shade_on;
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== src/csb_edit.sv =====
// field wrap logic: computes the values to write to the clock for one item
`default_nettype none

module csb_edit (
  input  csb_pkg::req_t        req,
  input  csb_pkg::ctrl_state_t state,
  output csb_pkg::date_time_t  dt,
  output logic [1:0]           write_kind
);

  logic       is_step;
  logic       up;
  logic [4:0] day_lim;
  logic [4:0] hours_step;
  logic [5:0] minutes_step;
  logic [3:0] month_step;
  logic [4:0] day_step;
  logic [6:0] year_step;

  assign is_step = (req.req_type == csb_pkg::KEY_PLUS) || (req.req_type == csb_pkg::KEY_MINUS);
  assign up      = (req.req_type == csb_pkg::KEY_PLUS);

  // month length, leap year every fourth year
  always_comb begin
    unique case (req.cur_month)
      4'd2: day_lim = (req.cur_year[1:0] == 2'd0) ? csb_pkg::DAYS_29 : csb_pkg::DAYS_28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: day_lim = csb_pkg::DAYS_31;
      default: day_lim = csb_pkg::DAYS_30;
    endcase
  end

  always_comb begin
    if (up) begin
      hours_step   = (req.cur_hours >= csb_pkg::HOUR_MAX) ? 5'd0 : req.cur_hours + 5'd1;
      minutes_step = (req.cur_minutes >= csb_pkg::MINUTE_MAX) ? 6'd0 : req.cur_minutes + 6'd1;
      month_step   = (req.cur_month >= csb_pkg::MONTH_MAX) ? 4'd1 : req.cur_month + 4'd1;
      day_step     = (req.cur_day >= day_lim) ? 5'd1 : req.cur_day + 5'd1;
      year_step    = (req.cur_year >= csb_pkg::YEAR_MAX) ? 7'd0 : req.cur_year + 7'd1;
    end else begin
      hours_step   = (req.cur_hours == 5'd0) ? csb_pkg::HOUR_MAX : req.cur_hours - 5'd1;
      minutes_step = (req.cur_minutes == 6'd0) ? csb_pkg::MINUTE_MAX : req.cur_minutes - 6'd1;
      month_step   = (req.cur_month <= 4'd1) ? csb_pkg::MONTH_MAX : req.cur_month - 4'd1;
      day_step     = (req.cur_day <= 5'd1) ? day_lim : req.cur_day - 5'd1;
      year_step    = (req.cur_year == 7'd0) ? csb_pkg::YEAR_MAX : req.cur_year - 7'd1;
    end
  end

  always_comb begin
    dt.hours   = req.cur_hours;
    dt.minutes = req.cur_minutes;
    dt.month   = req.cur_month;
    dt.day     = req.cur_day;
    dt.year    = req.cur_year;
    write_kind = csb_pkg::WR_NONE;
    if (is_step && state.edit) begin
      unique case (state.mode)
        csb_pkg::VIEW_TIME: begin
          if (state.sel) dt.hours = hours_step;
          else dt.minutes = minutes_step;
          write_kind = csb_pkg::WR_TIME;
        end
        csb_pkg::VIEW_DATE: begin
          if (state.sel) dt.month = month_step;
          else dt.day = day_step;
          write_kind = csb_pkg::WR_DATE;
        end
        csb_pkg::VIEW_YEAR: begin
          dt.year    = year_step;
          write_kind = csb_pkg::WR_DATE;
        end
        default: write_kind = csb_pkg::WR_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/csb_ctrl.sv =====
// view, edit, field select and shade state with its key-driven update
`default_nettype none

module csb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [1:0]           key,
  output csb_pkg::ctrl_state_t state,
  output csb_pkg::ctrl_state_t state_next,
  output logic                 leave
);

  always_comb begin
    state_next = state;
    leave      = 1'b0;
    unique case (key)
      csb_pkg::KEY_PLUS: begin
        if (!state.edit) begin
          state_next.mode = (state.mode >= csb_pkg::VIEW_YEAR) ? csb_pkg::VIEW_TIME
                                                                : state.mode + 2'd1;
        end
      end
      csb_pkg::KEY_MINUS: begin
        if (!state.edit) begin
          state_next.mode = (state.mode == csb_pkg::VIEW_TIME) ? csb_pkg::VIEW_YEAR
                                                                : state.mode - 2'd1;
        end
      end
      csb_pkg::KEY_SELECT: begin
        if (state.edit) begin
          if (state.mode != csb_pkg::VIEW_YEAR) begin
            state_next.sel   = ~state.sel;
            state_next.shade = state.sel ? csb_pkg::SHADE_LOW : csb_pkg::SHADE_HIGH;
          end else begin
            state_next.sel   = 1'b0;
            state_next.shade = csb_pkg::SHADE_LOW;
          end
        end else begin
          state_next.edit     = 1'b1;
          state_next.shade_on = 1'b1;
          state_next.sel      = 1'b0;
          state_next.shade    = csb_pkg::SHADE_LOW;
        end
      end
      default: begin
        if (state.edit) begin
          state_next.edit     = 1'b0;
          state_next.shade_on = 1'b0;
          state_next.sel      = 1'b0;
        end else begin
          leave = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/clock_set_button_controller_unit.sv =====
// path: an accepted item passes through the input register, then the result register
// throughput: one item per cycle while downstream does not stall; the result register frees when downstream takes it
// the state update for an item happens as it moves into the result register
// reset (rst, synchronous): both stages empty, time view, edit off, select 0,
// shade mask 0 and shading off
`default_nettype none

module clock_set_button_controller_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  csb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output csb_pkg::rsp_t rsp
);

  logic                 in_valid;
  csb_pkg::req_t        in_item;
  logic                 advance;
  logic                 accept;
  logic                 fire;
  csb_pkg::ctrl_state_t state;
  csb_pkg::ctrl_state_t state_next;
  logic                 leave;
  csb_pkg::date_time_t  dt;
  logic [1:0]           write_kind;
  csb_pkg::rsp_t        rsp_next;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = in_valid && !advance;
  assign accept    = req_valid && !req_stall;
  assign fire      = in_valid && advance;

  csb_edit u_edit (
    .req        (in_item),
    .state      (state),
    .dt         (dt),
    .write_kind (write_kind)
  );

  csb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .key        (in_item.req_type),
    .state      (state),
    .state_next (state_next),
    .leave      (leave)
  );

  always_comb begin
    rsp_next.new_hours     = dt.hours;
    rsp_next.new_minutes   = dt.minutes;
    rsp_next.new_month     = dt.month;
    rsp_next.new_day       = dt.day;
    rsp_next.new_year      = dt.year;
    rsp_next.write_kind    = write_kind;
    rsp_next.view_mode     = state_next.mode;
    rsp_next.editing       = state_next.edit;
    rsp_next.field_select  = state_next.sel;
    rsp_next.shade_pattern = state_next.shade;
    rsp_next.shade_on      = state_next.shade_on;
    rsp_next.leave_to_menu = leave;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) in_valid <= 1'b1;
      else if (fire) in_valid <= 1'b0;
      if (fire) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
    if (accept) in_item <= req;
    if (fire) rsp <= rsp_next;
  end

  a_write_only_editing: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.write_kind != csb_pkg::WR_NONE) |-> rsp.editing)
    else $error("clock write outside edit mode");

  a_leave_not_editing: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.leave_to_menu |-> !rsp.editing && (rsp.write_kind == csb_pkg::WR_NONE))
    else $error("menu request while editing or writing");

  a_shade_tracks_edit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.shade_on == rsp.editing))
    else $error("shading out of step with edit mode");

  a_year_single_field: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.editing && (rsp.view_mode == csb_pkg::VIEW_YEAR) |-> !rsp.field_select)
    else $error("field select set in year edit");

  a_state_moves_on_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state))
    else $error("control state changed without an item");

endmodule

`default_nettype wire
